[rtl/core/bpc_pkg.sv]
// ----------------------------------------------------------------------------
// bpc_pkg
// Shared types and constants of the button press classifier.
// ----------------------------------------------------------------------------
package bpc_pkg;

	// Input transfer: one millisecond tick of the sampled pin
	typedef struct packed {
		logic button_level;
		logic suppress;
	} bpc_in_t;

	// Result transfer: one classification
	typedef struct packed {
		logic [1:0]  press_kind;
		logic [1:0]  click_count;
		logic [15:0] first_duration_ms;
	} bpc_out_t;

	// Press kinds
	localparam logic [1:0] KIND_MULTI      = 2'd0;
	localparam logic [1:0] KIND_LONG_SHORT = 2'd1;
	localparam logic [1:0] KIND_LONG_LONG  = 2'd2;

	// Register indexes
	localparam logic [1:0] REG_DEBOUNCE   = 2'd0;
	localparam logic [1:0] REG_GAP        = 2'd1;
	localparam logic [1:0] REG_LONG_SHORT = 2'd2;
	localparam logic [1:0] REG_LONG_LONG  = 2'd3;

	// Register reset values
	localparam logic [7:0]  DEBOUNCE_RST   = 8'd10;
	localparam logic [15:0] GAP_RST        = 16'd450;
	localparam logic [15:0] LONG_SHORT_RST = 16'd1000;
	localparam logic [15:0] LONG_LONG_RST  = 16'd3000;

	// Valid press count saturates here
	localparam logic [1:0] COUNT_MAX = 2'd3;
	localparam logic [15:0] TIMER_MAX = 16'hFFFF;

endpackage

[rtl/core/button_press_classifier.sv]
// ----------------------------------------------------------------------------
// button_press_classifier
// Multi-click and long-press detector on millisecond ticks of a button pin.
// ----------------------------------------------------------------------------
// One input transfer is one millisecond tick; the block takes one tick every
// clock cycle while in_stall is low. Each tick updates the sequence state in
// the same cycle; when a sequence ends on a tick without suppress set, the
// classification is registered into a two-entry output buffer (output
// register plus skid slot) that separates the sides: in_stall rises only
// when both entries hold results not yet taken. Registers are written
// through the APB port at byte addresses 0, 4, 8 and 12 and act at once.
module button_press_classifier
	import bpc_pkg::*;
#(
	parameter int MAX_PRESSES = 3
) (
	input  logic        clk,
	input  logic        arst_n,
	// Tick channel
	input  logic        in_valid,
	output logic        in_stall,
	input  bpc_in_t     in_data,
	// Result channel
	output logic        out_valid,
	input  logic        out_stall,
	output bpc_out_t    out_data,
	// Configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int SLOT_W = (MAX_PRESSES > 1) ? $clog2(MAX_PRESSES) : 1;
	localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(MAX_PRESSES - 1);

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_PRESS,
		PH_GAP
	} phase_t;

	// Configuration registers
	logic [7:0]  debounce_q;
	logic [15:0] gap_ms_q;
	logic [15:0] long_short_q;
	logic [15:0] long_long_q;

	// Sequence state
	phase_t      phase_q, phase_d;
	logic        prev_level_q, prev_level_d;
	logic [15:0] hold_q, hold_d;
	logic [15:0] gap_q, gap_d;
	logic [SLOT_W-1:0] slot_q, slot_d;
	logic [1:0]  presses_q, presses_d;
	logic [15:0] first_q, first_d;

	// Output buffer
	logic        out_valid_q;
	bpc_out_t    out_q;
	logic        skid_valid_q;
	bpc_out_t    skid_q;

	logic        accept;
	logic        pop;
	logic        finish;
	logic        emit;
	logic [15:0] gap_inc;
	logic [15:0] hold_inc;
	bpc_out_t    result;
	logic        cfg_write;

	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite;
	assign in_stall  = skid_valid_q;
	assign accept    = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign pop       = out_valid_q && !out_stall;

	assign hold_inc = (hold_q == TIMER_MAX) ? hold_q : hold_q + 16'd1;
	assign gap_inc  = (gap_q == TIMER_MAX) ? gap_q : gap_q + 16'd1;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q   <= DEBOUNCE_RST;
			gap_ms_q     <= GAP_RST;
			long_short_q <= LONG_SHORT_RST;
			long_long_q  <= LONG_LONG_RST;
		end else if (cfg_write) begin
			unique case (paddr[3:2])
				REG_DEBOUNCE:   debounce_q   <= pwdata[7:0];
				REG_GAP:        gap_ms_q     <= pwdata[15:0];
				REG_LONG_SHORT: long_short_q <= pwdata[15:0];
				REG_LONG_LONG:  long_long_q  <= pwdata[15:0];
				default:        ;
			endcase
		end
	end

	// Read back configuration registers
	always_comb begin
		unique case (paddr[3:2])
			REG_DEBOUNCE:   prdata = {24'd0, debounce_q};
			REG_GAP:        prdata = {16'd0, gap_ms_q};
			REG_LONG_SHORT: prdata = {16'd0, long_short_q};
			REG_LONG_LONG:  prdata = {16'd0, long_long_q};
			default:        prdata = 32'd0;
		endcase
	end

	// Advance the sequence by one tick
	always_comb begin
		phase_d      = phase_q;
		prev_level_d = in_data.button_level;
		hold_d       = hold_q;
		gap_d        = gap_q;
		slot_d       = slot_q;
		presses_d    = presses_q;
		first_d      = first_q;
		finish       = 1'b0;
		unique case (phase_q)
			PH_IDLE: begin
				if (prev_level_q && !in_data.button_level) begin
					phase_d   = PH_PRESS;
					slot_d    = '0;
					presses_d = '0;
					first_d   = '0;
					hold_d    = 16'd1;
					gap_d     = '0;
				end
			end
			PH_PRESS: begin
				if (!in_data.button_level) begin
					hold_d = hold_inc;
				end else begin
					if (slot_q == '0) begin
						first_d = hold_q;
					end
					if ((hold_q > {8'd0, debounce_q}) && (presses_q < COUNT_MAX)) begin
						presses_d = presses_q + 2'd1;
					end
					gap_d   = '0;
					phase_d = PH_GAP;
					finish  = (gap_ms_q == '0);
				end
			end
			PH_GAP: begin
				gap_d = gap_inc;
				if (!in_data.button_level) begin
					if (slot_q == SLOT_LAST) begin
						finish = 1'b1;
					end else begin
						slot_d  = slot_q + SLOT_W'(1);
						hold_d  = 16'd1;
						phase_d = PH_PRESS;
					end
				end else if (gap_inc >= gap_ms_q) begin
					finish = 1'b1;
				end
			end
			default: begin
				phase_d = PH_IDLE;
			end
		endcase
		if (finish) begin
			phase_d = PH_IDLE;
		end
	end

	// Classify from the first press duration
	always_comb begin
		priority if (first_d >= long_long_q) begin
			result.press_kind = KIND_LONG_LONG;
		end else if (first_d >= long_short_q) begin
			result.press_kind = KIND_LONG_SHORT;
		end else begin
			result.press_kind = KIND_MULTI;
		end
		result.click_count       = presses_d;
		result.first_duration_ms = first_d;
	end

	assign emit = accept && finish && !in_data.suppress;

	// Hold sequence state and the output buffer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_IDLE;
			prev_level_q <= 1'b1;
			hold_q       <= '0;
			gap_q        <= '0;
			slot_q       <= '0;
			presses_q    <= '0;
			first_q      <= '0;
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				phase_q      <= phase_d;
				prev_level_q <= prev_level_d;
				hold_q       <= hold_d;
				gap_q        <= gap_d;
				slot_q       <= slot_d;
				presses_q    <= presses_d;
				first_q      <= first_d;
			end
			if (pop) begin
				if (skid_valid_q) begin
					out_q        <= skid_q;
					skid_valid_q <= emit;
					if (emit) begin
						skid_q <= result;
					end
				end else begin
					out_valid_q <= emit;
					if (emit) begin
						out_q <= result;
					end
				end
			end else if (emit) begin
				if (!out_valid_q) begin
					out_valid_q <= 1'b1;
					out_q       <= result;
				end else begin
					skid_valid_q <= 1'b1;
					skid_q       <= result;
				end
			end
		end
	end

endmodule
